>>> rtl/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KSC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define KSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

>>> rtl/ksc_pkg.sv
package ksc_pkg;

   localparam int LETTER_COUNT = 26;
   localparam int IDX_W        = 5;
   localparam int BYTE_W       = 8;

   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7A;

   // req_type codes
   localparam logic REQ_KEY  = 1'b0;
   localparam logic REQ_TEXT = 1'b1;

   // direction register codes
   localparam logic DIR_ENCRYPT = 1'b0;
   localparam logic DIR_DECRYPT = 1'b1;

   localparam logic [IDX_W-1:0] LAST_LETTER = IDX_W'(LETTER_COUNT - 1);
   localparam logic [IDX_W:0]   FILL_FULL   = (IDX_W + 1)'(LETTER_COUNT);

   typedef logic [IDX_W-1:0] letter_type;

   typedef struct packed {
      logic       is_letter;
      letter_type idx;
   } decode_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_FILL = 2'b10
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic text_accept;
      logic key_accept;
      logic walk_step;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic skid_full;
      logic walk_last;
   } status_type;

   // Letter position 0..25 with case folded; is_letter low for anything else.
   function automatic decode_type letter_decode(input logic [BYTE_W-1:0] b);
      decode_type d;
      logic [BYTE_W-1:0] diff;
      d    = '0;
      diff = '0;
      if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
         diff        = b - CHAR_UPPER_A;
         d.is_letter = 1'b1;
         d.idx       = diff[IDX_W-1:0];
      end else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
         diff        = b - CHAR_LOWER_A;
         d.is_letter = 1'b1;
         d.idx       = diff[IDX_W-1:0];
      end
      return d;
   endfunction

endpackage

>>> rtl/ksc_ctrl.sv
module ksc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_type,
   input  logic                req_key_last,
   output logic                req_ready,
   input  ksc_pkg::status_type status,
   output ksc_pkg::cmd_type    cmd
);

   ksc_pkg::state_type state_ff, state_in;
   logic accept;

   assign req_ready = (state_ff == ksc_pkg::ST_IDLE) && !status.skid_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      case (state_ff)
         ksc_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_type == ksc_pkg::REQ_TEXT) begin
                  cmd.text_accept = 1'b1;
               end else begin
                  cmd.key_accept = 1'b1;
                  if (req_key_last) begin
                     state_in = ksc_pkg::ST_FILL;
                  end
               end
            end
         end
         ksc_pkg::ST_FILL: begin
            // one unused-letter candidate per cycle
            cmd.walk_step = 1'b1;
            if (status.walk_last) begin
               state_in = ksc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ksc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ksc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/ksc_datapath.sv
module ksc_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic                csr_direction,
   input  logic [7:0]          req_in_byte,
   input  ksc_pkg::cmd_type    cmd,
   output ksc_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte
);

   localparam int N = ksc_pkg::LETTER_COUNT;

   logic                      dir_ff, dir_in;
   ksc_pkg::letter_type       fwd_ff [N];
   ksc_pkg::letter_type       inv_ff [N];
   logic [N-1:0]              used_ff, used_in;
   logic [ksc_pkg::IDX_W:0]   fill_ff, fill_in;
   logic                      ready_ff, ready_in;
   ksc_pkg::letter_type       walk_ff, walk_in;

   logic                      out_valid_ff, out_valid_in;
   logic [7:0]                out_byte_ff, out_byte_in;
   logic                      skid_valid_ff, skid_valid_in;
   logic [7:0]                skid_byte_ff, skid_byte_in;

   ksc_pkg::decode_type       dec;
   ksc_pkg::letter_type       mapped;
   logic [7:0]                text_res;
   logic                      restart;
   logic [N-1:0]              used_eff;
   logic [ksc_pkg::IDX_W:0]   fill_eff;
   ksc_pkg::letter_type       place_idx;
   logic                      place_cand;
   logic                      do_place;
   logic                      out_take;

   assign dec = ksc_pkg::letter_decode(req_in_byte);

   // text lookup
   assign mapped   = (dir_ff == ksc_pkg::DIR_DECRYPT) ? inv_ff[dec.idx] : fwd_ff[dec.idx];
   assign text_res = (ready_ff && dec.is_letter) ?
                     ksc_pkg::CHAR_UPPER_A + {3'b000, mapped} : req_in_byte;

   // placement of one letter: a keyword letter or a walk candidate
   assign restart    = cmd.key_accept && ready_ff;
   assign used_eff   = restart ? '0 : used_ff;
   assign fill_eff   = restart ? '0 : fill_ff;
   assign place_idx  = cmd.walk_step ? walk_ff : dec.idx;
   assign place_cand = cmd.walk_step || (cmd.key_accept && dec.is_letter);
   assign do_place   = place_cand && !used_eff[place_idx] && (fill_eff < ksc_pkg::FILL_FULL);

   always_comb begin
      dir_in   = csr_write ? csr_direction : dir_ff;
      used_in  = used_eff;
      fill_in  = fill_eff;
      ready_in = ready_ff;
      walk_in  = walk_ff;
      if (cmd.key_accept) begin
         ready_in = 1'b0;
         walk_in  = '0;
      end
      if (do_place) begin
         used_in[place_idx] = 1'b1;
         fill_in            = fill_eff + 1'b1;
      end
      if (cmd.walk_step) begin
         walk_in = walk_ff + 1'b1;
         if (status.walk_last) begin
            ready_in = 1'b1;
         end
      end
   end

   assign status.walk_last = (walk_ff == ksc_pkg::LAST_LETTER);
   assign status.skid_full = skid_valid_ff;

   // output register with a skid stage behind it
   assign out_take = out_valid_ff && rsp_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      skid_valid_in = skid_valid_ff;
      skid_byte_in  = skid_byte_ff;
      if (out_take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_byte_in   = skid_byte_ff;
            skid_valid_in = 1'b0;
         end else if (cmd.text_accept) begin
            out_valid_in = 1'b1;
            out_byte_in  = text_res;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (cmd.text_accept) begin
         skid_valid_in = 1'b1;
         skid_byte_in  = text_res;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff        <= ksc_pkg::DIR_ENCRYPT;
         used_ff       <= '0;
         fill_ff       <= '0;
         ready_ff      <= 1'b1;
         walk_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         for (int i = 0; i < N; i++) begin
            fwd_ff[i] <= ksc_pkg::IDX_W'(i);
            inv_ff[i] <= ksc_pkg::IDX_W'(i);
         end
      end else begin
         dir_ff        <= dir_in;
         used_ff       <= used_in;
         fill_ff       <= fill_in;
         ready_ff      <= ready_in;
         walk_ff       <= walk_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (do_place) begin
            fwd_ff[fill_eff[ksc_pkg::IDX_W-1:0]] <= place_idx;
            inv_ff[place_idx] <= fill_eff[ksc_pkg::IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff  <= out_byte_in;
      skid_byte_ff <= skid_byte_in;
   end

endmodule

>>> rtl/keyword_substitution_cipher.sv
// Keyword substitution cipher. Keyword items (req_type 0) build a mixed
// 26-letter alphabet: each new letter, case folded, takes the next slot, and
// the item flagged req_key_last closes the table by appending the unused
// letters A..Z in order. A keyword item after a finished table starts a new
// one. Text items (req_type 1) return one rsp item each: letters come back
// upper case, mapped forward (csr_direction 0) or inverse (1); non-letters
// pass unchanged. Until the first keyword the table is the identity; while a
// keyword is still open, text passes through untouched. The final keyword
// item is followed by a fill walk over the letters A..Z (one candidate
// letter per cycle through the single placement port of the tables), during
// which req_ready is low. A text item's result is registered in the output
// register; with rsp_ready high, text items stream at one per cycle outside
// the fill walk. A skid stage holds one more result, so one text item is
// still taken while the output waits. Write csr_direction only while the
// block is idle; csr_ready is always high.
module keyword_substitution_cipher (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_direction,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_type,
   input  logic [7:0] req_in_byte,
   input  logic       req_key_last,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte
);

   ksc_pkg::cmd_type    cmd;
   ksc_pkg::status_type status;

   // register write always completes at once
   assign csr_ready = 1'b1;

   ksc_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_type     (req_type),
      .req_key_last (req_key_last),
      .req_ready    (req_ready),
      .status       (status),
      .cmd          (cmd)
   );

   ksc_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_valid && csr_ready),
      .csr_direction (csr_direction),
      .req_in_byte   (req_in_byte),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte)
   );

endmodule

>>> rtl/ksc_checker.sv
`include "assert_macros.svh"

module ksc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_type,
   input logic       req_key_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte
);

   // a waiting result holds still
   `KSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte))

   // a result only shows up after a text item went in
   `KSC_ASSERT_SAME(a_rsp_cause, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready && req_type))

   // the closing keyword item starts the fill walk
   `KSC_ASSERT_NEXT(a_fill_busy, clock, reset, req_valid && req_ready && !req_type && req_key_last, !req_ready)

endmodule

bind keyword_substitution_cipher ksc_checker u_ksc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_type     (req_type),
   .req_key_last (req_key_last),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_byte (rsp_out_byte)
);
